>>> hdl/fir_pkg.sv
// shared types and constants for the streaming fir filter
package fir_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 18;
    localparam int PROD_W          = SAMPLE_W + COEF_W;
    localparam int COEF_IDX_W      = 8;
    localparam int TAP_CNT_W       = 9;
    localparam int TAP_COUNT_RESET = 137;
    localparam int FRAC_SHIFT      = 17;
    localparam int ROUND_HALF      = 65536;
    localparam int SAMPLE_MAX      = 32767;
    localparam int SAMPLE_MIN_MAG  = 32768;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    // control broadcast to the history cells; the head cell has clear tied low
    typedef struct packed
    {
        logic shift;
        logic clear;
        logic rotate;
    } ring_ctrl_t;

    // control for the multiply-accumulate unit
    typedef struct packed
    {
        logic clear_acc;
        logic tap_en;
        logic load_en;
    } mac_ctrl_t;

endpackage

>>> hdl/fir_cell.sv
// one history cell of the sample ring
module fir_cell
    import fir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ring_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] newer_data,
    input  logic signed [SAMPLE_W-1:0] older_data,
    output logic signed [SAMPLE_W-1:0] data
);

    logic signed [SAMPLE_W-1:0] data_reg;
    logic signed [SAMPLE_W-1:0] data_next;

    // shift moves toward older slots, rotate moves toward the head
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = ctrl.clear ? '0 : newer_data;
        end
        else if (ctrl.rotate)
        begin
            data_next = older_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

>>> hdl/fir_mac.sv
// coefficient store and pipelined multiply-accumulate
module fir_mac
    import fir_pkg::*;
#(
    parameter int MAX_TAPS = 256,
    parameter int IDX_W    = $clog2(MAX_TAPS),
    parameter int ACC_W    = PROD_W + $clog2(MAX_TAPS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic [IDX_W-1:0]           load_addr,
    input  logic signed [COEF_W-1:0]   load_value,
    input  logic [IDX_W-1:0]           rd_addr,
    input  logic signed [SAMPLE_W-1:0] head_sample,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];

    logic signed [COEF_W-1:0]   coef_b_reg;
    logic signed [SAMPLE_W-1:0] hist_b_reg;
    logic                       en_b_reg;
    logic signed [PROD_W-1:0]   prod_c_reg;
    logic signed [PROD_W-1:0]   prod_c_next;
    logic                       en_c_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            coef_mem[load_addr] <= load_value;
        end
        coef_b_reg <= coef_mem[rd_addr];
        hist_b_reg <= head_sample;
        prod_c_reg <= prod_c_next;
    end

    assign prod_c_next = PROD_W'(hist_b_reg) * PROD_W'(coef_b_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear_acc)
        begin
            acc_next = '0;
        end
        else if (en_c_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_c_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_b_reg <= 1'b0;
            en_c_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            en_b_reg <= ctrl.tap_en;
            en_c_reg <= en_b_reg;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> hdl/fir_filter_stream.sv
// streaming direct-form fir filter: ring of history cells and one shared mac
// a sample transaction closes the input until its result is loaded into the output register
// coefficient loads: one per cycle while the core is idle
// each sample pass rotates the history ring once fully past the single multiplier
// reset: history cleared to zero, tap_count back to 137, coefficient store left unwritten
module fir_filter_stream
    import fir_pkg::*;
#(
    parameter int MAX_TAPS = 256
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic                        first_sample,
    input  logic                        last_sample,
    input  logic signed [COEF_W-1:0]    coef_value,
    input  logic [COEF_IDX_W-1:0]       coef_index,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        saturated,
    output logic                        end_of_stream,
    // tap_count register write
    input  logic                        cfg_wr_en,
    input  logic [TAP_CNT_W-1:0]        cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int LIM_W = (CNT_W > TAP_CNT_W) ? CNT_W : TAP_CNT_W;
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(SAMPLE_MIN_MAG));

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [CNT_W-1:0]            step_reg;
    logic [CNT_W-1:0]            step_next;
    logic                        drain_reg;
    logic                        drain_next;
    logic [TAP_CNT_W-1:0]        tap_count_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [SAMPLE_W-1:0]  sample_out_reg;
    logic                        saturated_reg;
    logic                        eos_reg;

    logic                        accept;
    logic                        accept_sample;
    logic                        accept_load;
    logic                        out_load;
    logic [CNT_W-1:0]            tap_limit;
    logic [LIM_W-1:0]            tc_ext;
    logic [IDX_W+COEF_IDX_W-1:0] ci_ext;
    logic                        ci_in_range;

    ring_ctrl_t                  ring_ctrl;
    mac_ctrl_t                   mac_ctrl;
    logic signed [SAMPLE_W-1:0]  hist_data [MAX_TAPS];
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     acc_rounded;
    logic signed [ACC_W-1:0]     acc_scaled;
    logic signed [SAMPLE_W-1:0]  y_sat;
    logic                        y_clip;

    // handshake
    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign accept_sample = accept && (opcode == OP_SAMPLE);
    assign accept_load   = accept && (opcode == OP_LOAD);

    // coefficient index beyond the store is dropped
    assign ci_ext      = {{IDX_W{1'b0}}, coef_index};
    assign ci_in_range = (32'(coef_index) < MAX_TAPS);

    // taps in use: zero counts as one, anything above the store depth is clipped
    assign tc_ext = LIM_W'(tap_count_reg);
    always_comb
    begin
        priority if (tc_ext == '0)
        begin
            tap_limit = CNT_W'(1);
        end
        else if (tc_ext > LIM_W'(MAX_TAPS))
        begin
            tap_limit = CNT_W'(MAX_TAPS);
        end
        else
        begin
            tap_limit = tc_ext[CNT_W-1:0];
        end
    end

    // history ring: cell 0 holds the newest sample, rotation brings older ones to the head
    assign ring_ctrl.shift  = accept_sample;
    assign ring_ctrl.clear  = first_sample;
    assign ring_ctrl.rotate = (state_reg == ST_RUN);

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_ring
        ring_ctrl_t cell_ctrl;

        if (k == 0)
        begin : g_head
            // head cell always takes the incoming sample, even on a stream start
            assign cell_ctrl.shift  = ring_ctrl.shift;
            assign cell_ctrl.clear  = 1'b0;
            assign cell_ctrl.rotate = ring_ctrl.rotate;

            fir_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .newer_data (sample_in),
                .older_data (hist_data[(k + 1) % MAX_TAPS]),
                .data       (hist_data[k])
            );
        end
        else
        begin : g_body
            assign cell_ctrl = ring_ctrl;

            fir_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .newer_data (hist_data[k - 1]),
                .older_data (hist_data[(k + 1) % MAX_TAPS]),
                .data       (hist_data[k])
            );
        end
    end

    // mac: step m multiplies coef[m] by the sample m slots back
    assign mac_ctrl.clear_acc = accept_sample;
    assign mac_ctrl.tap_en    = (state_reg == ST_RUN) && (step_reg < tap_limit);
    assign mac_ctrl.load_en   = accept_load && ci_in_range;

    fir_mac #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W),
        .ACC_W    (ACC_W)
    ) u_mac
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .load_addr   (ci_ext[IDX_W-1:0]),
        .load_value  (coef_value),
        .rd_addr     (step_reg[IDX_W-1:0]),
        .head_sample (hist_data[0]),
        .acc         (acc)
    );

    // round half up, scale back to q1.15, clip to 16 bits
    assign acc_rounded = acc + ACC_W'(ROUND_HALF);
    assign acc_scaled  = acc_rounded >>> FRAC_SHIFT;

    always_comb
    begin
        priority if (acc_scaled > Y_MAX)
        begin
            y_sat  = SAMPLE_W'(Y_MAX);
            y_clip = 1'b1;
        end
        else if (acc_scaled < Y_MIN)
        begin
            y_sat  = SAMPLE_W'(Y_MIN);
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = acc_scaled[SAMPLE_W-1:0];
            y_clip = 1'b0;
        end
    end

    // output register frees the core as soon as a result lands in it
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_sample)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                // hold here while the product and accumulate stages flush; drain_reg marks the exit
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            drain_reg     <= 1'b0;
            tap_count_reg <= TAP_CNT_W'(TAP_COUNT_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tap_count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_sample)
        begin
            last_reg <= last_sample;
        end
        if (out_load)
        begin
            sample_out_reg <= y_sat;
            saturated_reg  <= y_clip;
            eos_reg        <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign saturated     = saturated_reg;
    assign end_of_stream = eos_reg;

endmodule

>>> hdl/fir_checker.sv
// port-level checks for the streaming fir filter, bound to the top level
module fir_checker
    import fir_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       opcode,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] sample_out,
    input logic                       saturated,
    input logic                       end_of_stream
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out) && $stable(saturated)
            && $stable(end_of_stream))
        else $error("result payload changed while stalled");

    // a clipped result sits at one of the rails
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (sample_out == 16'sh7fff || sample_out == 16'sh8000))
        else $error("saturated flag without a rail value");

    // a coefficient load transaction leaves the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_LOAD) |=> in_ready)
        else $error("coefficient load stalled the input");

    // a sample transaction closes the input while the taps are worked through
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_SAMPLE) |=> !in_ready)
        else $error("input open during a filter pass");

endmodule

bind fir_filter_stream fir_checker u_fir_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .saturated     (saturated),
    .end_of_stream (end_of_stream)
);
